/* src/nfba_pkg.sv */
package nfba_pkg;

  // Fixed widths of the channel fields
  localparam int REQ_W  = 1;
  localparam int IDX_W  = 4;
  localparam int SZ_W   = 16;
  localparam int INT_W  = 32;
  localparam int EXT_W  = 20;

  // Request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  // Configuration port
  localparam int          APB_AW = 3;
  localparam int          APB_DW = 32;
  localparam int          CFG_W  = 5;
  localparam logic        REG_BLOCKS_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0] BLOCKS_IN_USE_RST = 5'd16;

  // Saturation limits of the totals
  localparam logic [INT_W-1:0] INT_MAX = 32'hFFFF_FFFF;
  localparam logic [EXT_W-1:0] EXT_MAX = 20'hF_FFFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_RD,
    S_LOAD_WR,
    S_SCAN,
    S_FINISH
  } nfba_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic load_rd;
    logic load_wr;
    logic scan;
    logic load_out;
  } nfba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_range;
    logic hit;
    logic exhausted;
  } nfba_sts_t;

endpackage

/* src/nfba_datapath.sv */
module nfba_datapath import nfba_pkg::*; #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  nfba_cmd_t        cmd,
  output nfba_sts_t        sts,
  input  logic [CFG_W-1:0] blocks_in_use,
  input  logic [REQ_W-1:0] in_req_type,
  input  logic [IDX_W-1:0] in_block_index,
  input  logic [SZ_W-1:0]  in_size,
  output logic             out_granted,
  output logic [IDX_W-1:0] out_chosen_block,
  output logic [INT_W-1:0] out_internal_frag_total,
  output logic [EXT_W-1:0] out_external_frag_total
);

  localparam int IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int NBW = $clog2(MAX_BLOCKS + 1);
  localparam int CW  = (NBW > CFG_W) ? NBW : CFG_W;
  localparam int FW  = SIZE_WIDTH + IW + 1;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_BLOCKS);

  // Block size store, valid and taken flags
  logic [SIZE_WIDTH-1:0] mem [MAX_BLOCKS];
  logic [SIZE_WIDTH-1:0] rd_data_r;
  logic [MAX_BLOCKS-1:0] valid_r, valid_nxt;
  logic [MAX_BLOCKS-1:0] taken_r, taken_nxt;

  // Item registers
  logic [IW-1:0]         idx_r;
  logic [SIZE_WIDTH-1:0] req_r;
  logic [CW-1:0]         n_r;

  // Scan pipeline: issue stage and check stage
  logic [IW-1:0]         addr_r, addr_nxt;
  logic [CW-1:0]         iss_cnt_r, iss_cnt_nxt;
  logic                  chk_v_r, chk_v_nxt;
  logic [IW-1:0]         chk_idx_r, chk_idx_nxt;

  // Persistent allocator state
  logic [IW-1:0]         start_r, start_nxt;
  logic [INT_W-1:0]      int_r, int_nxt;
  logic [FW-1:0]         free_r, free_nxt;

  // Result of the current item
  logic                  res_granted_r, res_granted_nxt;
  logic [IW-1:0]         res_block_r, res_block_nxt;

  logic [31:0]           sz32, idx32, blk32;
  logic [SIZE_WIDTH-1:0] in_sz;
  logic [IW-1:0]         in_idx, rd_addr;
  logic [CW-1:0]         biu_c, n_eff, start_c, addr_inc, chk_inc;
  logic [SIZE_WIDTH-1:0] blk_size, old_free, diff;
  logic [INT_W:0]        int_sum;
  logic [63:0]           fs64;
  logic                  issue, fit;

  // Input decode
  always_comb begin
    sz32    = 32'(in_size);
    idx32   = 32'(in_block_index);
    in_sz   = sz32[SIZE_WIDTH-1:0];
    in_idx  = idx32[IW-1:0];
    biu_c   = CW'(blocks_in_use);
    n_eff   = (biu_c > MAX_C) ? MAX_C : biu_c;
    start_c = (CW'(start_r) < n_eff) ? CW'(start_r) : '0;
  end

  // Check stage: does the block just read fit the request
  always_comb begin
    blk_size = valid_r[chk_idx_r] ? rd_data_r : '0;
    fit      = cmd.scan && chk_v_r && !taken_r[chk_idx_r] && (blk_size >= req_r);
    diff     = blk_size - req_r;
    int_sum  = {1'b0, int_r} + (INT_W+1)'(diff);
    chk_inc  = CW'(chk_idx_r) + 1'b1;
    addr_inc = CW'(addr_r) + 1'b1;
    issue    = cmd.scan && (iss_cnt_r < n_r);
    old_free = (valid_r[idx_r] && !taken_r[idx_r]) ? rd_data_r : '0;
    rd_addr  = cmd.load_rd ? idx_r : addr_r;
  end

  assign sts.in_range  = idx32 < 32'(MAX_BLOCKS);
  assign sts.hit       = fit;
  assign sts.exhausted = cmd.scan && !chk_v_r && (iss_cnt_r == n_r);

  // Next state of the datapath registers
  always_comb begin
    valid_nxt       = valid_r;
    taken_nxt       = taken_r;
    addr_nxt        = addr_r;
    iss_cnt_nxt     = iss_cnt_r;
    chk_v_nxt       = chk_v_r;
    chk_idx_nxt     = chk_idx_r;
    start_nxt       = start_r;
    int_nxt         = int_r;
    free_nxt        = free_r;
    res_granted_nxt = res_granted_r;
    res_block_nxt   = res_block_r;

    if (cmd.accept) begin
      res_granted_nxt = 1'b0;
      res_block_nxt   = '0;
      addr_nxt        = start_c[IW-1:0];
      iss_cnt_nxt     = '0;
      chk_v_nxt       = 1'b0;
    end

    // Load: old free size out, new size in
    if (cmd.load_wr) begin
      valid_nxt[idx_r] = 1'b1;
      taken_nxt[idx_r] = 1'b0;
      free_nxt         = free_r - FW'(old_free) + FW'(req_r);
      res_granted_nxt  = 1'b1;
      res_block_nxt    = idx_r;
    end

    // Scan: one read issued and one block checked per cycle
    if (cmd.scan) begin
      chk_v_nxt   = issue;
      chk_idx_nxt = addr_r;
      if (issue) begin
        addr_nxt    = (addr_inc < n_r) ? addr_inc[IW-1:0] : '0;
        iss_cnt_nxt = iss_cnt_r + 1'b1;
      end
    end

    if (fit) begin
      taken_nxt[chk_idx_r] = 1'b1;
      int_nxt         = int_sum[INT_W] ? INT_MAX : int_sum[INT_W-1:0];
      free_nxt        = free_r - FW'(blk_size);
      start_nxt       = (chk_inc < n_r) ? chk_inc[IW-1:0] : '0;
      res_granted_nxt = 1'b1;
      res_block_nxt   = chk_idx_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= '0;
      taken_r       <= '0;
      start_r       <= '0;
      int_r         <= '0;
      free_r        <= '0;
      chk_v_r       <= 1'b0;
      iss_cnt_r     <= '0;
      res_granted_r <= 1'b0;
    end else begin
      valid_r       <= valid_nxt;
      taken_r       <= taken_nxt;
      start_r       <= start_nxt;
      int_r         <= int_nxt;
      free_r        <= free_nxt;
      chk_v_r       <= chk_v_nxt;
      iss_cnt_r     <= iss_cnt_nxt;
      res_granted_r <= res_granted_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    chk_idx_r   <= chk_idx_nxt;
    res_block_r <= res_block_nxt;
    if (cmd.accept) begin
      idx_r <= in_idx;
      req_r <= in_sz;
      n_r   <= (in_req_type == REQ_ALLOC) ? n_eff : '0;
    end
  end

  // Size store, registered read
  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      mem[idx_r] <= req_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Result register
  always_comb begin
    fs64  = 64'(free_r);
    blk32 = 32'(res_block_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_granted             <= res_granted_r;
      out_chosen_block        <= blk32[IDX_W-1:0];
      out_internal_frag_total <= int_r;
      out_external_frag_total <= (fs64 > 64'(EXT_MAX)) ? EXT_MAX : fs64[EXT_W-1:0];
    end
  end

endmodule

/* src/nfba_ctrl.sv */
module nfba_ctrl import nfba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [REQ_W-1:0] in_req_type,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output nfba_cmd_t        cmd,
  input  nfba_sts_t        sts
);

  nfba_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_req_type == REQ_LOAD) begin
            state_nxt = sts.in_range ? S_LOAD_RD : S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_LOAD_RD: begin
        cmd.load_rd = 1'b1;
        state_nxt   = S_LOAD_WR;
      end
      S_LOAD_WR: begin
        cmd.load_wr = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit || sts.exhausted) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for the result register to be free
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // a scan either finds a block or runs out, never both
  a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.hit && sts.exhausted))
    else $error("scan hit and exhausted together");

  // a loaded result is always offered next cycle
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result loaded but not offered");

  // an accepted beat makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> in_stall)
    else $error("block not busy after accept");

  // a load write always follows its read
  a_load_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_wr |-> $past(state_r) == S_LOAD_RD)
    else $error("load write without read");

endmodule

/* src/next_fit_block_allocator_unit.sv */
// Next-fit fixed-partition block allocator.
// Input channel (in_valid / in_stall): one beat is either a load, which writes
// one block's size and marks it free, or an allocate, which scans the blocks
// circularly from the saved start index for the first free block that is big
// enough. Output channel (out_valid / out_stall): one beat per input beat with
// grant flag, block index, the saturating internal fragmentation total and the
// saturating sum of free block sizes.
// APB port: one register, blocks_in_use at byte address 0 (reset 16).
// Timing: a load passes from the accept through the S_LOAD_RD, S_LOAD_WR and
// S_FINISH states (an index out of range goes straight to S_FINISH); an
// allocate goes through S_SCAN, which ends on a grant or once all n blocks
// are checked (n is blocks_in_use clamped to MAX_BLOCKS), then S_FINISH. The
// scan reads the size store and checks the previous read, one block per cycle.
// Items are handled one at a time; in_stall is high from the accept until the
// result has moved into the output register, when the next beat can be taken.
// A stalled result holds and the next beat can be taken and worked on
// meanwhile; it then waits to finish.
// Reset (synchronous, rst_n low) frees and zeroes all blocks, clears both
// totals and the start index; no clearing pass is needed.
module next_fit_block_allocator_unit import nfba_pkg::*; #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [IDX_W-1:0]  in_block_index,
  input  logic [SZ_W-1:0]   in_size,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_granted,
  output logic [IDX_W-1:0]  out_chosen_block,
  output logic [INT_W-1:0]  out_internal_frag_total,
  output logic [EXT_W-1:0]  out_external_frag_total,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [CFG_W-1:0] blocks_in_use_r;
  logic             reg_sel;
  nfba_cmd_t        cmd;
  nfba_sts_t        sts;

  // Register decode
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_BLOCKS_IN_USE);
  assign prdata  = reg_sel ? APB_DW'(blocks_in_use_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_in_use_r <= BLOCKS_IN_USE_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      blocks_in_use_r <= pwdata[CFG_W-1:0];
    end
  end

  nfba_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .sts         (sts)
  );

  nfba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_datapath (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .sts                     (sts),
    .blocks_in_use           (blocks_in_use_r),
    .in_req_type             (in_req_type),
    .in_block_index          (in_block_index),
    .in_size                 (in_size),
    .out_granted             (out_granted),
    .out_chosen_block        (out_chosen_block),
    .out_internal_frag_total (out_internal_frag_total),
    .out_external_frag_total (out_external_frag_total)
  );

endmodule
